// ===== hdl/sar_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor auto-ranging package
// Shared types, register indexes and constants of the auto-ranging unit.
// ----------------------------------------------------------------------------
package sar_pkg;

    // Default width of one raw converter channel.
    localparam int RAW_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_TINT   = 2'd0;
    localparam logic [1:0] REG_MAX_TINT     = 2'd1;
    localparam logic [1:0] REG_FULL_TINT    = 2'd2;
    localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd3;

    // Register reset values.
    localparam logic [3:0] START_TINT_RESET   = 4'd8;
    localparam logic [3:0] MAX_TINT_RESET     = 4'd9;
    localparam logic [3:0] FULL_TINT_RESET    = 4'd10;
    localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd4;

    // Ranging constants.
    localparam logic [4:0] TINT_BASE    = 5'd10;
    localparam logic [4:0] TINT_STEP    = 5'd2;
    localparam logic [3:0] ATTEMPTS_CAP = 4'd8;
    localparam logic [1:0] GAIN_MAX     = 2'd3;
    localparam int         TINT_MAX     = 15;
    localparam int         GAIN_TOP     = 3;
    localparam int         MAX_LSHIFT   = TINT_MAX + 2 * GAIN_TOP;

    // Per-channel scale factors.
    localparam logic [6:0] FACTOR_X = 7'd33;
    localparam logic [6:0] FACTOR_Y = 7'd32;
    localparam logic [6:0] FACTOR_Z = 7'd69;

    // Scaled value width and the result bus width.
    localparam int SCALED_W  = 31;
    localparam int M_TDATA_W = 104;

    // Configuration register set.
    typedef struct packed {
        logic [3:0] start_tint;
        logic [3:0] max_tint;
        logic [3:0] full_tint;
        logic [3:0] max_attempts;
    } cfg_t;

    // Ranging decision for the reading in the input register.
    typedef struct packed {
        logic       done;
        logic       mid;
        logic [3:0] next_tint;
        logic [1:0] next_gain;
        logic [3:0] tint;
        logic [1:0] gain;
    } rng_dec_t;

endpackage
`default_nettype wire

// ===== hdl/sar_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor auto-ranging configuration registers
// Holds the four ranging registers, written by index over the write channel.
// ----------------------------------------------------------------------------
module sar_cfg_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [3:0]    cfg_wdata,
    output sar_pkg::cfg_t      cfg
);
    import sar_pkg::*;

    cfg_t cfg_reg;

    // Writes are always accepted; cfg_ready is tied high.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register file update on a write transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_tint   <= START_TINT_RESET;
            cfg_reg.max_tint     <= MAX_TINT_RESET;
            cfg_reg.full_tint    <= FULL_TINT_RESET;
            cfg_reg.max_attempts <= MAX_ATTEMPTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_START_TINT:   cfg_reg.start_tint   <= cfg_wdata;
                REG_MAX_TINT:     cfg_reg.max_tint     <= cfg_wdata;
                REG_FULL_TINT:    cfg_reg.full_tint    <= cfg_wdata;
                REG_MAX_ATTEMPTS: cfg_reg.max_attempts <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sar_range_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor auto-ranging control
// Classifies a reading against the current full scale and steps the
// integration time, gain and attempt count.
// ----------------------------------------------------------------------------
module sar_range_ctrl #(
    parameter int RAW_BITS = sar_pkg::RAW_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sar_pkg::cfg_t       cfg,
    input  wire logic [RAW_BITS-1:0] raw_x,
    input  wire logic [RAW_BITS-1:0] raw_y,
    input  wire logic [RAW_BITS-1:0] raw_z,
    input  wire logic                advance,
    output sar_pkg::rng_dec_t        dec
);
    import sar_pkg::*;

    logic [3:0]          tint_reg;
    logic [1:0]          gain_reg;
    logic [2:0]          attempt_reg;
    logic [4:0]          fs_exp;
    logic [RAW_BITS-1:0] full_scale;
    logic [RAW_BITS-1:0] eighth;
    logic [RAW_BITS-1:0] top;
    logic                low;
    logic                high;
    logic                mid;
    logic [3:0]          limit;
    logic [3:0]          taken;
    logic                done;
    logic [4:0]          tint_up;
    logic [3:0]          nt;
    logic [1:0]          ng;

    // Full scale is a run of ones, capped by the raw channel width.
    assign fs_exp = {1'b0, tint_reg} + TINT_BASE;
    always_comb begin
        for (int i = 0; i < RAW_BITS; i++) begin
            full_scale[i] = (i < int'(fs_exp));
        end
    end

    assign eighth = full_scale >> 3;
    assign top    = full_scale - eighth;

    // Band classification.
    assign low  = (raw_x < eighth) && (raw_y < eighth) && (raw_z < eighth);
    assign high = !low && ((raw_x >= top) || (raw_y >= top) || (raw_z >= top));
    assign mid  = !low && !high;

    // Attempt limit, clamped to one through eight.
    always_comb begin
        if (cfg.max_attempts == 4'd0) begin
            limit = 4'd1;
        end else if (cfg.max_attempts > ATTEMPTS_CAP) begin
            limit = ATTEMPTS_CAP;
        end else begin
            limit = cfg.max_attempts;
        end
    end

    assign taken = {1'b0, attempt_reg} + 4'd1;
    assign done  = mid || (taken >= limit);

    // Next settings for a reading that asks for another attempt.
    assign tint_up = {1'b0, tint_reg} + TINT_STEP;
    always_comb begin
        nt = tint_reg;
        ng = gain_reg;
        if (low) begin
            if (tint_up > {1'b0, cfg.max_tint}) begin
                nt = cfg.max_tint;
            end else begin
                nt = tint_up[3:0];
            end
        end else if (high) begin
            if (gain_reg != GAIN_MAX) begin
                ng = gain_reg + 2'd1;
            end
        end
    end

    // Decision handed to the result stage.
    always_comb begin
        dec.done      = done;
        dec.mid       = mid;
        dec.next_tint = done ? cfg.start_tint : nt;
        dec.next_gain = done ? 2'd0 : ng;
        dec.tint      = tint_reg;
        dec.gain      = gain_reg;
    end

    // Ranging state moves on as each reading passes to the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tint_reg    <= START_TINT_RESET;
            gain_reg    <= 2'd0;
            attempt_reg <= 3'd0;
        end else if (advance) begin
            if (done) begin
                tint_reg    <= cfg.start_tint;
                gain_reg    <= 2'd0;
                attempt_reg <= 3'd0;
            end else begin
                tint_reg    <= nt;
                gain_reg    <= ng;
                attempt_reg <= taken[2:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sar_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor auto-ranging scaler
// Shifts each channel by the exposure and gain difference, applies the
// channel factor and saturates to 31 bits.
// ----------------------------------------------------------------------------
module sar_scaler #(
    parameter int RAW_BITS = sar_pkg::RAW_BITS_DEF
) (
    input  wire logic [RAW_BITS-1:0]          raw_x,
    input  wire logic [RAW_BITS-1:0]          raw_y,
    input  wire logic [RAW_BITS-1:0]          raw_z,
    input  wire logic [3:0]                   tint,
    input  wire logic [1:0]                   gain,
    input  wire logic [3:0]                   full_tint,
    input  wire logic                         done,
    output logic [sar_pkg::SCALED_W-1:0]      scaled_x,
    output logic [sar_pkg::SCALED_W-1:0]      scaled_y,
    output logic [sar_pkg::SCALED_W-1:0]      scaled_z
);
    import sar_pkg::*;

    // The shifted value is held wide enough to detect overflow past 31 bits.
    localparam int WIDE_W = (RAW_BITS + MAX_LSHIFT > SCALED_W + 1) ?
                            RAW_BITS + MAX_LSHIFT : SCALED_W + 1;
    localparam int PROD_W = SCALED_W + 7;

    logic signed [6:0] shift;
    logic [6:0]        shift_neg;
    logic [4:0]        lsh;
    logic [3:0]        rsh;

    // Signed total shift: reference tint minus tint plus twice the gain.
    assign shift     = $signed({3'b000, full_tint}) - $signed({3'b000, tint})
                     + $signed({4'b0000, gain, 1'b0});
    assign shift_neg = -shift;
    assign lsh       = shift[4:0];
    assign rsh       = shift_neg[3:0];

    // One channel: shift, multiply by its factor, saturate.
    function automatic logic [SCALED_W-1:0] scale_one(
        input logic [RAW_BITS-1:0] raw,
        input logic [6:0]          factor,
        input logic                right,
        input logic [4:0]          lamt,
        input logic [3:0]          ramt
    );
        logic [WIDE_W-1:0] wide;
        logic              over;
        logic [PROD_W-1:0] prod;
        if (right) begin
            wide = WIDE_W'(raw >> ramt);
        end else begin
            wide = WIDE_W'(raw) << lamt;
        end
        over = |wide[WIDE_W-1:SCALED_W];
        prod = PROD_W'(wide[SCALED_W-1:0]) * PROD_W'(factor);
        if (over || (|prod[PROD_W-1:SCALED_W])) begin
            scale_one = {SCALED_W{1'b1}};
        end else begin
            scale_one = prod[SCALED_W-1:0];
        end
    endfunction

    // Scaled values are only reported for a finished reading.
    always_comb begin
        if (done) begin
            scaled_x = scale_one(raw_x, FACTOR_X, shift[6], lsh, rsh);
            scaled_y = scale_one(raw_y, FACTOR_Y, shift[6], lsh, rsh);
            scaled_z = scale_one(raw_z, FACTOR_Z, shift[6], lsh, rsh);
        end else begin
            scaled_x = '0;
            scaled_y = '0;
            scaled_z = '0;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sensor_auto_ranging_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted reading passes through the input register and then the result register to the master side.
// One reading per cycle is taken while the result register is free or draining; a master-side stall holds both.
// Ranging state advances as each reading moves into the result register.
// Reset (aresetn low, synchronous) empties both registers, restores the
// configuration defaults and returns to tint 8, gain 0, no attempts taken.
// ----------------------------------------------------------------------------
// Sensor auto-ranging unit
// Top level: input register, ranging control, scaler and result register.
// ----------------------------------------------------------------------------
module sensor_auto_ranging_unit #(
    parameter int  RAW_BITS  = sar_pkg::RAW_BITS_DEF,
    localparam int S_TDATA_W = ((3 * RAW_BITS + 7) / 8) * 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Slave side: raw_x, raw_y, raw_z from the lowest bit up.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [S_TDATA_W-1:0]          s_tdata,
    // Master side tdata: next_tint, next_gain, scaled_x, scaled_y, scaled_z.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sar_pkg::M_TDATA_W-1:0]      m_tdata,
    // Master side tuser: done_res, in_range from the lowest bit up.
    output logic [1:0]                         m_tuser,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_addr,
    input  wire logic [3:0]                    cfg_wdata
);
    import sar_pkg::*;

    localparam int DATA_USED = 6 + 3 * SCALED_W;

    cfg_t                cfg;
    rng_dec_t            dec;
    logic                in_vld_reg;
    logic [RAW_BITS-1:0] raw_x_reg;
    logic [RAW_BITS-1:0] raw_y_reg;
    logic [RAW_BITS-1:0] raw_z_reg;
    logic                advance;
    logic [SCALED_W-1:0] scaled_x;
    logic [SCALED_W-1:0] scaled_y;
    logic [SCALED_W-1:0] scaled_z;
    logic                out_vld_reg;
    logic                done_reg;
    logic                in_range_reg;
    logic [3:0]          next_tint_reg;
    logic [1:0]          next_gain_reg;
    logic [SCALED_W-1:0] scaled_x_reg;
    logic [SCALED_W-1:0] scaled_y_reg;
    logic [SCALED_W-1:0] scaled_z_reg;

    sar_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The input register moves on when the result register is free or draining.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            raw_x_reg <= s_tdata[RAW_BITS-1:0];
            raw_y_reg <= s_tdata[2*RAW_BITS-1:RAW_BITS];
            raw_z_reg <= s_tdata[3*RAW_BITS-1:2*RAW_BITS];
        end
    end

    sar_range_ctrl #(
        .RAW_BITS (RAW_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .raw_x   (raw_x_reg),
        .raw_y   (raw_y_reg),
        .raw_z   (raw_z_reg),
        .advance (advance),
        .dec     (dec)
    );

    sar_scaler #(
        .RAW_BITS (RAW_BITS)
    ) u_scale (
        .raw_x     (raw_x_reg),
        .raw_y     (raw_y_reg),
        .raw_z     (raw_z_reg),
        .tint      (dec.tint),
        .gain      (dec.gain),
        .full_tint (cfg.full_tint),
        .done      (dec.done),
        .scaled_x  (scaled_x),
        .scaled_y  (scaled_y),
        .scaled_z  (scaled_z)
    );

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (advance) begin
            done_reg      <= dec.done;
            in_range_reg  <= dec.done && dec.mid;
            next_tint_reg <= dec.next_tint;
            next_gain_reg <= dec.next_gain;
            scaled_x_reg  <= scaled_x;
            scaled_y_reg  <= scaled_y;
            scaled_z_reg  <= scaled_z;
        end
    end

    // Master side packing.
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = {in_range_reg, done_reg};
    assign m_tdata  = {{(M_TDATA_W - DATA_USED){1'b0}}, scaled_z_reg, scaled_y_reg,
                       scaled_x_reg, next_gain_reg, next_tint_reg};

endmodule
`default_nettype wire
